@@ design/dtd_pkg.sv @@
// Shared constants, codes and the tile swizzle for the display tile detiler.
// No dependencies.
package dtd_pkg;

  localparam int unsigned MaxDimension = 16384;
  localparam int unsigned TileEdgeLog2 = 7;

  localparam int unsigned DimW  = 15;
  localparam int unsigned CoordW = 14;
  localparam int unsigned WordW = 32;
  localparam int unsigned FmtW  = 64;
  localparam int unsigned OffW  = 30;
  localparam int unsigned SizeW = 31;
  localparam int unsigned TileCntW = 8;
  localparam int unsigned TileCoordW = CoordW - TileEdgeLog2;

  localparam logic [FmtW-1:0] TenBitFlag = 64'h0100_0000_0000_0000;
  localparam logic [FmtW-1:0] FormatBgra = 64'h8000_0000_0000_0000;
  localparam logic [FmtW-1:0] FormatRgba = 64'h8000_0000_2200_0000;

  localparam logic [DimW-1:0] DimMax = DimW'(MaxDimension);

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadDim  = 2'd1,
    StBadFmt  = 2'd2,
    StOutside = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgFormat = 2'd2
  } cfg_idx_e;

  // XOR bit swizzle of the pixel position inside one 64 KiB tile
  function automatic logic [15:0] tile_swizzle(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    logic [15:0] xe;
    logic [15:0] ye;
    xe = {2'b00, x};
    ye = {2'b00, y};
    return ((ye << 4) & 16'h0070) ^ ((ye << 5) & 16'h0f00) ^ ((ye << 9) & 16'h1000)
         ^ ((ye << 8) & 16'h4000) ^ ((xe << 2) & 16'h000c) ^ ((xe << 5) & 16'h0380)
         ^ ((xe << 4) & 16'h0400) ^ ((xe << 6) & 16'h0800) ^ ((xe << 9) & 16'ha000);
  endfunction

endpackage

@@ design/display_tile_detiler.sv @@
// Display tile detiler: one pixel per clock, input register then result register.
// start_i reaches done_o via input and result register; a request is taken every
// cycle and busy_o stays low. The width/height multipliers are the longest paths.
// The receiver cannot stall: done_o is high for exactly one cycle per result; the
// result holds until the next. Configuration (width, height, format) must be written
// only while idle; the block does not enforce it. Depends on dtd_pkg.
module display_tile_detiler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [dtd_pkg::CoordW-1:0]  pixel_x_i,
  input  logic [dtd_pkg::CoordW-1:0]  pixel_y_i,
  input  logic [dtd_pkg::WordW-1:0]   source_word_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [dtd_pkg::FmtW-1:0]    cfg_data_i,
  output logic                        done_o,
  output logic [dtd_pkg::OffW-1:0]    tiled_offset_o,
  output logic [dtd_pkg::OffW-1:0]    linear_offset_o,
  output logic [dtd_pkg::WordW-1:0]   out_pixel_o,
  output logic [dtd_pkg::SizeW-1:0]   buffer_bytes_o,
  output logic [1:0]                  status_o
);
  import dtd_pkg::*;

  logic [DimW-1:0]   width_q, height_q;
  logic [FmtW-1:0]   format_q;

  logic              vld_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [WordW-1:0]  word_q;

  logic              done_q;
  logic [OffW-1:0]   tiled_q, linear_q;
  logic [WordW-1:0]  pixel_q;
  logic [SizeW-1:0]  size_q;
  status_e           status_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
      format_q <= FormatBgra;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgWidth:  width_q  <= cfg_data_i[DimW-1:0];
        CfgHeight: height_q <= cfg_data_i[DimW-1:0];
        CfgFormat: format_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= pixel_x_i;
      y_q    <= pixel_y_i;
      word_q <= source_word_i;
    end
  end

  // per-pixel compute
  logic [FmtW-1:0]       fmt_base;
  logic                  ten_bit, rgba, dims_ok, fmt_ok, in_image;
  logic [DimW:0]         across_sum, down_sum;
  logic [TileCntW-1:0]   across, down;
  logic [2*TileCntW-1:0] tile_total;
  logic [TileCoordW+TileCntW-1:0] tile_row;
  logic [TileCoordW+TileCntW-1:0] tile_idx;
  logic [15:0]           swz;
  logic [CoordW+DimW-1:0] lin_mul;
  logic [CoordW+DimW-1:0] lin_pix;
  logic [7:0]            ch0, ch1, ch2, ch3;
  logic [OffW-1:0]       tiled_d, linear_d;
  logic [WordW-1:0]      pixel_d;
  logic [SizeW-1:0]      size_d;
  status_e               status_d;

  always_comb begin
    fmt_base = format_q & ~TenBitFlag;
    ten_bit  = (format_q & TenBitFlag) != '0;
    rgba     = fmt_base == FormatRgba;
    fmt_ok   = (fmt_base == FormatBgra) || rgba;
    dims_ok  = (width_q != '0) && (height_q != '0) && (width_q <= DimMax) && (height_q <= DimMax);
    in_image = ({1'b0, x_q} < width_q) && ({1'b0, y_q} < height_q);

    across_sum = {1'b0, width_q}  + (DimW+1)'((1 << TileEdgeLog2) - 1);
    down_sum   = {1'b0, height_q} + (DimW+1)'((1 << TileEdgeLog2) - 1);
    across     = across_sum[TileEdgeLog2 +: TileCntW];
    down       = down_sum[TileEdgeLog2 +: TileCntW];
    tile_total = (2*TileCntW)'(across) * (2*TileCntW)'(down);

    tile_row = (TileCoordW+TileCntW)'(y_q[CoordW-1:TileEdgeLog2])
             * (TileCoordW+TileCntW)'(across);
    tile_idx = tile_row + (TileCoordW+TileCntW)'(x_q[CoordW-1:TileEdgeLog2]);
    swz      = tile_swizzle(x_q, y_q);

    lin_mul  = (CoordW+DimW)'(y_q) * (CoordW+DimW)'(width_q);
    lin_pix  = lin_mul + (CoordW+DimW)'(x_q);

    if (ten_bit) begin
      ch0 = rgba ? word_q[29:22] : word_q[9:2];
      ch1 = word_q[19:12];
      ch2 = rgba ? word_q[9:2] : word_q[29:22];
      ch3 = 8'hff;
    end else begin
      ch0 = rgba ? word_q[23:16] : word_q[7:0];
      ch1 = word_q[15:8];
      ch2 = rgba ? word_q[7:0] : word_q[23:16];
      ch3 = word_q[31:24];
    end

    tiled_d  = '0;
    linear_d = '0;
    pixel_d  = '0;
    size_d   = '0;
    priority if (!dims_ok) begin
      status_d = StBadDim;
    end else if (!fmt_ok) begin
      status_d = StBadFmt;
    end else begin
      size_d = {tile_total[SizeW-17:0], 16'h0000};
      if (!in_image) begin
        status_d = StOutside;
      end else begin
        status_d = StOk;
        tiled_d  = {tile_idx[OffW-17:0], swz};
        linear_d = {lin_pix[OffW-3:0], 2'b00};
        pixel_d  = {ch3, ch2, ch1, ch0};
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      tiled_q  <= tiled_d;
      linear_q <= linear_d;
      pixel_q  <= pixel_d;
      size_q   <= size_d;
      status_q <= status_d;
    end
  end

  assign done_o          = done_q;
  assign tiled_offset_o  = tiled_q;
  assign linear_offset_o = linear_q;
  assign out_pixel_o     = pixel_q;
  assign buffer_bytes_o  = size_q;
  assign status_o        = status_q;

  // every request yields a result, through the input register and the result register
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> ##1 done_o)
    else $error("request produced no result");

  // faults carry no offsets or pixel
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != StOk) |->
      (tiled_offset_o == '0) && (linear_offset_o == '0) && (out_pixel_o == '0))
    else $error("faulted result carries data");

  // no buffer size without a valid geometry and format
  a_fault_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ((status_o == StBadDim) || (status_o == StBadFmt)) |-> buffer_bytes_o == '0)
    else $error("buffer size reported on configuration fault");

endmodule
